// ===== rtl/spring_damped_point_update_macros.svh =====
// Assertion macros for the damped spring point block.
// Included by files that check their own logic; no other dependencies.
`ifndef SPRING_DAMPED_POINT_UPDATE_MACROS_SVH
`define SPRING_DAMPED_POINT_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define SDP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define SDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SDP_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sdp_pkg.sv =====
// Shared types and constants for the damped spring point block.
// No dependencies.
package sdp_pkg;
    localparam int NUM_POINTS = 64;
    localparam int IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int SQ_IN_W = 60;
    localparam int SQ_OUT_W = 30;

    // Table entry, one per point
    typedef struct packed {
        logic signed [20:0] cur_x;
        logic signed [20:0] cur_y;
        logic signed [20:0] vel_x;
        logic signed [20:0] vel_y;
        logic [19:0]        cur_depth;
        logic signed [19:0] vel_depth;
        logic [18:0]        home_x;
        logic [18:0]        home_y;
        logic [3:0]         base_size;
    } entry_t;

    // Square root unit status
    typedef struct packed {
        logic busy;
    } sq_status_t;

    // Round to nearest right shift by 16, ties away from zero
    function automatic logic signed [63:0] rshr16(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        begin
            m = x[63] ? (64'd0 - x) : x;
            r = (m + 64'd32768) >> 16;
            return x[63] ? -$signed(r) : $signed(r);
        end
    endfunction
endpackage

// ===== rtl/sdp_mul.sv =====
// Shared signed 32 x 32 multiplier with registered product.
// Depends on sdp_pkg.
module sdp_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod
);
    import sdp_pkg::*;

    logic signed [63:0] prod_reg;

    // Register each product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

// ===== rtl/sdp_isqrt.sv =====
// Iterative floor integer square root, two radicand bits per cycle.
// Depends on sdp_pkg.
module sdp_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sdp_pkg::SQ_IN_W-1:0]   din,
    output sdp_pkg::sq_status_t           status,
    output logic [sdp_pkg::SQ_OUT_W-1:0]  root
);
    import sdp_pkg::*;

    logic [SQ_IN_W-1:0] v_reg, v_next;
    logic [SQ_IN_W-1:0] res_reg, res_next;
    logic [SQ_IN_W-1:0] bit_reg, bit_next;
    logic [SQ_IN_W-1:0] trial;

    // One digit step per cycle
    always_comb
    begin
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        trial = res_reg + bit_reg;
        if (start)
        begin
            v_next = din;
            res_next = '0;
            bit_next = {2'b01, {(SQ_IN_W-2){1'b0}}};
        end
        else if (bit_reg != '0)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        res_reg <= res_next;
    end

    assign status.busy = (bit_reg != '0);
    assign root = res_reg[SQ_OUT_W-1:0];
endmodule

// ===== rtl/spring_damped_point_update.sv =====
// Damped spring point table: a load is written straight from idle, a step runs
// through the sequencer states, paced by the 30-iteration square root and the single
// shared multiplier; one item at a time, s_tready high only when idle.
// Reset (rst_n, async low) clears control and sets gains to defaults;
// the point table is not cleared and holds nothing until loaded.
// Depends on sdp_pkg, sdp_mul, sdp_isqrt and the macros header.
`include "spring_damped_point_update_macros.svh"
module spring_damped_point_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // point_index[5:0], pos_x[24:6], pos_y[43:25], dot_size[47:44]
    input  logic [47:0] s_tdata,
    // op[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_index[5:0], out_x[26:6], out_y[47:27], out_radius[63:48]
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdp_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0, S_RD = 5'd1, S_DX = 5'd2, S_DY = 5'd3,
        S_TG = 5'd4, S_EX = 5'd5, S_VX = 5'd6, S_UX = 5'd7, S_EY = 5'd8,
        S_VY = 5'd9, S_UY = 5'd10, S_HX = 5'd11, S_HY = 5'd12, S_SQ = 5'd13,
        S_SW = 5'd14, S_DV = 5'd15, S_TZ = 5'd16, S_VZ = 5'd17, S_UZ = 5'd18,
        S_RAD = 5'd19, S_OUT = 5'd20;
    localparam logic [1:0] REG_SPRING = 2'd0, REG_FRICTION = 2'd1, REG_PUSH = 2'd2;
    localparam logic [31:0] RECIP_400 = 32'd687194768;

    function automatic logic signed [20:0] sat21(input logic signed [63:0] v);
        begin
            if (v < -64'sd1048576) return -21'sd1048576;
            else if (v > 64'sd1048575) return 21'sd1048575;
            else return v[20:0];
        end
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
        begin
            if (v < -64'sd524288) return -20'sd524288;
            else if (v > 64'sd524287) return 20'sd524287;
            else return v[19:0];
        end
    endfunction

    function automatic logic [19:0] satu20(input logic signed [63:0] v);
        begin
            if (v < 0) return 20'd0;
            else if (v > 64'sd1048575) return 20'hFFFFF;
            else return v[19:0];
        end
    endfunction

    function automatic logic signed [63:0] mag(input logic signed [63:0] v);
        begin
            return v[63] ? -v : v;
        end
    endfunction

    // Configuration registers
    logic [15:0] sg_reg, fr_reg;
    logic [11:0] pr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_reg <= 16'd2025;
            fr_reg <= 16'd57888;
            pr_reg <= 12'd600;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SPRING:   sg_reg <= pwdata[15:0];
                REG_FRICTION: fr_reg <= pwdata[15:0];
                REG_PUSH:     pr_reg <= pwdata[11:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SPRING:   prdata = {16'd0, sg_reg};
            REG_FRICTION: prdata = {16'd0, fr_reg};
            REG_PUSH:     prdata = {20'd0, pr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Input fields
    logic              in_op;
    logic [5:0]        in_idx;
    logic [18:0]       in_px, in_py;
    logic [3:0]        in_sz;
    logic              in_acc, in_ok;

    assign in_op = s_tuser[0];
    assign in_idx = s_tdata[5:0];
    assign in_px = s_tdata[24:6];
    assign in_py = s_tdata[43:25];
    assign in_sz = s_tdata[47:44];
    assign in_ok = (32'(in_idx) < NUM_POINTS);
    assign in_acc = s_tvalid && s_tready;

    // Sequencer and datapath registers
    logic [4:0]         state_reg, state_next;
    logic [5:0]         idx_reg, idx_next;
    logic [18:0]        px_reg, px_next, py_reg, py_next;
    entry_t             ent_reg;
    logic [39:0]        rr_reg, rr_next;
    logic [43:0]        acc_reg, acc_next;
    logic signed [22:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [23:0] e_reg, e_next;
    logic signed [20:0] nx_reg, nx_next, nvx_reg, nvx_next;
    logic signed [20:0] ny_reg, ny_next, nvy_reg, nvy_next;
    logic [19:0]        tz_reg, tz_next, cz_reg, cz_next;
    logic signed [20:0] dz_reg, dz_next;
    logic signed [19:0] vz_reg, vz_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        out_data_reg, out_data_next;

    // Memory port signals
    entry_t             mem [NUM_POINTS];
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    // Shared units
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic               sq_start;
    logic [SQ_IN_W-1:0] sq_din;
    sq_status_t         sq_stat;
    logic [SQ_OUT_W-1:0] sq_root;

    sdp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

    sdp_isqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .din(sq_din),
        .status(sq_stat), .root(sq_root)
    );

    // Combinational temporaries
    logic signed [22:0] dx, dy;
    logic signed [21:0] hx, hy;
    logic [44:0]        d2;
    logic signed [63:0] v1, vv, tzw, radw;
    logic               near;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        px_next = px_reg;
        py_next = py_reg;
        rr_next = rr_reg;
        acc_next = acc_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        e_next = e_reg;
        nx_next = nx_reg;
        nvx_next = nvx_reg;
        ny_next = ny_reg;
        nvy_next = nvy_reg;
        tz_next = tz_reg;
        cz_next = cz_reg;
        dz_next = dz_reg;
        vz_next = vz_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        mul_a = '0;
        mul_b = '0;
        sq_start = 1'b0;
        sq_din = {acc_reg + prod[43:0], 16'd0};
        wr_en = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = ent_reg;
        dx = $signed({4'd0, px_reg}) - 23'(ent_reg.cur_x);
        dy = $signed({4'd0, py_reg}) - 23'(ent_reg.cur_y);
        hx = $signed({3'd0, ent_reg.home_x}) - 22'(nx_reg);
        hy = $signed({3'd0, ent_reg.home_y}) - 22'(ny_reg);
        d2 = {1'b0, acc_reg} + {1'b0, prod[43:0]};
        near = (d2 < {5'd0, rr_reg});
        v1 = '0;
        vv = '0;
        tzw = '0;
        radw = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_ok)
                begin
                    idx_next = in_idx;
                    px_next = in_px;
                    py_next = in_py;
                    if (in_op)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        // Load: place point at home, at rest
                        wr_en = 1'b1;
                        wr_addr = in_idx[IDX_W-1:0];
                        wr_data.cur_x = 21'(in_px);
                        wr_data.cur_y = 21'(in_py);
                        wr_data.vel_x = '0;
                        wr_data.vel_y = '0;
                        wr_data.cur_depth = '0;
                        wr_data.vel_depth = '0;
                        wr_data.home_x = in_px;
                        wr_data.home_y = in_py;
                        wr_data.base_size = in_sz;
                    end
                end
            end
            S_RD:
            begin
                mul_a = 32'(pr_reg);
                mul_b = 32'(pr_reg);
                state_next = S_DX;
            end
            S_DX:
            begin
                rr_next = {prod[23:0], 16'd0};
                mul_a = 32'(dx);
                mul_b = 32'(dx);
                state_next = S_DY;
            end
            S_DY:
            begin
                acc_next = prod[43:0];
                mul_a = 32'(dy);
                mul_b = 32'(dy);
                state_next = S_TG;
            end
            S_TG:
            begin
                // Mirror the pointer inside the push radius, else go home
                if (near)
                begin
                    tx_next = 23'(ent_reg.cur_x) - dx;
                    ty_next = 23'(ent_reg.cur_y) - dy;
                end
                else
                begin
                    tx_next = $signed({4'd0, ent_reg.home_x});
                    ty_next = $signed({4'd0, ent_reg.home_y});
                end
                state_next = S_EX;
            end
            S_EX:
            begin
                e_next = 24'(tx_reg) - 24'(ent_reg.cur_x);
                mul_a = 32'(e_next);
                mul_b = $signed({16'd0, sg_reg});
                state_next = S_VX;
            end
            S_VX:
            begin
                v1 = 64'(ent_reg.vel_x) + rshr16(prod);
                mul_a = v1[31:0];
                mul_b = $signed({16'd0, fr_reg});
                state_next = S_UX;
            end
            S_UX:
            begin
                vv = 64'(sat21(rshr16(prod)));
                if (mag(64'(e_reg)) <= 64'sd102 && mag(vv) <= 64'sd10)
                begin
                    nvx_next = '0;
                    nx_next = sat21(64'(tx_reg));
                end
                else
                begin
                    nvx_next = vv[20:0];
                    nx_next = sat21(64'(ent_reg.cur_x) + vv);
                end
                state_next = S_EY;
            end
            S_EY:
            begin
                e_next = 24'(ty_reg) - 24'(ent_reg.cur_y);
                mul_a = 32'(e_next);
                mul_b = $signed({16'd0, sg_reg});
                state_next = S_VY;
            end
            S_VY:
            begin
                v1 = 64'(ent_reg.vel_y) + rshr16(prod);
                mul_a = v1[31:0];
                mul_b = $signed({16'd0, fr_reg});
                state_next = S_UY;
            end
            S_UY:
            begin
                vv = 64'(sat21(rshr16(prod)));
                if (mag(64'(e_reg)) <= 64'sd102 && mag(vv) <= 64'sd10)
                begin
                    nvy_next = '0;
                    ny_next = sat21(64'(ty_reg));
                end
                else
                begin
                    nvy_next = vv[20:0];
                    ny_next = sat21(64'(ent_reg.cur_y) + vv);
                end
                state_next = S_HX;
            end
            S_HX:
            begin
                mul_a = 32'(hx);
                mul_b = 32'(hx);
                state_next = S_HY;
            end
            S_HY:
            begin
                acc_next = prod[43:0];
                mul_a = 32'(hy);
                mul_b = 32'(hy);
                state_next = S_SQ;
            end
            S_SQ:
            begin
                sq_start = 1'b1;
                state_next = S_SW;
            end
            S_SW:
            begin
                if (!sq_stat.busy)
                begin
                    state_next = S_DV;
                end
            end
            S_DV:
            begin
                // Divide by 400 through a reciprocal, rounded to nearest
                mul_a = $signed({1'b0, 31'(sq_root) + 31'd200});
                mul_b = $signed(RECIP_400);
                state_next = S_TZ;
            end
            S_TZ:
            begin
                tzw = (prod >>> 38) + 64'sd65536;
                tz_next = satu20(tzw);
                dz_next = $signed({1'b0, tz_next}) - $signed({1'b0, ent_reg.cur_depth});
                mul_a = 32'(dz_next);
                mul_b = $signed({16'd0, sg_reg});
                state_next = S_VZ;
            end
            S_VZ:
            begin
                v1 = 64'(ent_reg.vel_depth) + rshr16(prod);
                mul_a = v1[31:0];
                mul_b = $signed({16'd0, fr_reg});
                state_next = S_UZ;
            end
            S_UZ:
            begin
                vv = 64'(sat20(rshr16(prod)));
                if (mag(64'(dz_reg)) <= 64'sd655 && mag(vv) <= 64'sd65)
                begin
                    cz_next = tz_reg;
                    vz_next = '0;
                end
                else
                begin
                    cz_next = satu20($signed({44'd0, ent_reg.cur_depth}) + vv);
                    vz_next = vv[19:0];
                end
                state_next = S_RAD;
            end
            S_RAD:
            begin
                mul_a = $signed({28'd0, ent_reg.base_size});
                mul_b = $signed({12'd0, cz_reg});
                state_next = S_OUT;
            end
            S_OUT:
            begin
                radw = (prod + 64'sd32) >>> 6;
                if (radw < 64'sd256) radw = 64'sd256;
                else if (radw > 64'sd65535) radw = 64'sd65535;
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    wr_en = 1'b1;
                    wr_data.cur_x = nx_reg;
                    wr_data.cur_y = ny_reg;
                    wr_data.vel_x = nvx_reg;
                    wr_data.vel_y = nvy_reg;
                    wr_data.cur_depth = cz_reg;
                    wr_data.vel_depth = vz_reg;
                    out_valid_next = 1'b1;
                    out_data_next = {radw[15:0], ny_reg, nx_reg, idx_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Point table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_RD)
        begin
            ent_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        px_reg <= px_next;
        py_reg <= py_next;
        rr_reg <= rr_next;
        acc_reg <= acc_next;
        tx_reg <= tx_next;
        ty_reg <= ty_next;
        e_reg <= e_next;
        nx_reg <= nx_next;
        nvx_reg <= nvx_next;
        ny_reg <= ny_next;
        nvy_reg <= nvy_next;
        tz_reg <= tz_next;
        cz_reg <= cz_next;
        dz_reg <= dz_next;
        vz_reg <= vz_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    `SDP_ASSERT_ALWAYS(a_sq_start_free, clk, rst_n, !(sq_start && sq_stat.busy))
    `SDP_ASSERT_NEXT(a_step_reads, clk, rst_n, in_acc && in_op, state_reg == S_RD)
    `SDP_ASSERT_ALWAYS(a_wr_out_free, clk, rst_n,
        !(state_reg == S_OUT && wr_en && out_valid_reg && !m_tready))
endmodule
